[sv/angle_frame_parser_with_status_macros.svh]
// Assertion macros for the angle frame parser.
`ifndef ANGLE_FRAME_PARSER_WITH_STATUS_MACROS_SVH
`define ANGLE_FRAME_PARSER_WITH_STATUS_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define AFP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("afp assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define AFP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("afp assertion failed");

`endif

[sv/afp_pkg.sv]
// Package: types, constants and register map of the angle frame parser.
`default_nettype none
package afp_pkg;

  localparam int BYTE_W    = 8;
  localparam int DATA_W    = 32;
  localparam int REG_IDX_W = 2;
  localparam int ADDR_W    = REG_IDX_W + 2;
  localparam int POS_W     = 3;
  localparam int CNT_W     = 3;

  localparam logic [REG_IDX_W-1:0] REG_SYNC       = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_ANGLE_LOW  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_ANGLE_HIGH = 2'd2;

  localparam logic [BYTE_W-1:0]        SYNC_RESET       = 8'h79;
  localparam logic signed [BYTE_W-1:0] ANGLE_LOW_RESET  = -8'sd120;
  localparam logic signed [BYTE_W-1:0] ANGLE_HIGH_RESET = 8'sd120;

  localparam logic [BYTE_W-1:0] MODE_OK    = 8'h00;
  localparam logic [BYTE_W-1:0] MODE_ERR   = 8'h01;
  localparam logic [BYTE_W-1:0] CODE_OK    = 8'h01;
  localparam logic [BYTE_W-1:0] CODE_FULL  = 8'h02;
  localparam logic [BYTE_W-1:0] CODE_RANGE = 8'h03;
  localparam logic [BYTE_W-1:0] CODE_CSUM  = 8'h04;

  localparam logic [POS_W-1:0] POS_IDLE  = 3'd0;
  localparam logic [POS_W-1:0] POS_FIRST = 3'd1;
  localparam logic [POS_W-1:0] POS_CSUM  = 3'd4;

  localparam logic [CNT_W-1:0] LAST_SHORT = 3'd3;
  localparam logic [CNT_W-1:0] LAST_LONG  = 3'd7;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    REPLY_OK    = 2'd0,
    REPLY_FULL  = 2'd1,
    REPLY_RANGE = 2'd2,
    REPLY_CSUM  = 2'd3
  } reply_kind_t;

  typedef struct packed {
    reply_kind_t               kind;
    logic signed [BYTE_W-1:0]  angle_first;
    logic signed [BYTE_W-1:0]  angle_second;
    logic signed [BYTE_W-1:0]  angle_third;
  } reply_desc_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  typedef struct packed {
    logic [BYTE_W-1:0]        sync_byte;
    logic signed [BYTE_W-1:0] angle_low;
    logic signed [BYTE_W-1:0] angle_high;
  } cfg_t;

endpackage
`default_nettype wire

[sv/afp_in_if.sv]
// Input channel: received byte words with the downstream queue flag.
`default_nettype none
interface afp_in_if;
  import afp_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;
  logic              queue_full;
  modport source(output valid, rx_byte, queue_full, input ready);
  modport sink(input valid, rx_byte, queue_full, output ready);
endinterface
`default_nettype wire

[sv/afp_out_if.sv]
// Output channel: status reply words with the angle command.
`default_nettype none
interface afp_out_if;
  import afp_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [BYTE_W-1:0]        tx_byte;
  logic                     cmd_valid;
  logic signed [BYTE_W-1:0] angle_first;
  logic signed [BYTE_W-1:0] angle_second;
  logic signed [BYTE_W-1:0] angle_third;
  logic                     last;
  modport source(output valid, tx_byte, cmd_valid, angle_first, angle_second,
                 angle_third, last, input ready);
  modport sink(input valid, tx_byte, cmd_valid, angle_first, angle_second,
               angle_third, last, output ready);
endinterface
`default_nettype wire

[sv/angle_frame_parser_with_status.sv]
// Top level: angle frame parser with status replies and APB register port.
// A completed frame's first reply word is valid once its descriptor is
// queued and loaded into the back end; frames that do not complete give none.
// One input word per cycle while the two-entry reply queue has room; the
// output serializer sends four words per reply, eight for queue full.
// Reset (synchronous): registers to defaults, hunt restarts, queue empties.
`default_nettype none
`include "angle_frame_parser_with_status_macros.svh"
module angle_frame_parser_with_status (
  input  wire logic                        clk,
  input  wire logic                        rst,
  afp_in_if.sink                           rx_ch,
  afp_out_if.source                        tx_ch,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [afp_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [afp_pkg::DATA_W-1:0]  pwdata,
  output      logic [afp_pkg::DATA_W-1:0]  prdata,
  output      logic                        pready
);
  import afp_pkg::*;

  cfg_t                 cfg;
  logic                 cfg_wr;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 push;
  logic                 pop;
  reply_desc_t          push_desc;
  reply_desc_t          pop_desc;
  queue_status_t        q_stat;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sync_byte  <= SYNC_RESET;
      cfg.angle_low  <= ANGLE_LOW_RESET;
      cfg.angle_high <= ANGLE_HIGH_RESET;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_SYNC:       cfg.sync_byte  <= pwdata[BYTE_W-1:0];
        REG_ANGLE_LOW:  cfg.angle_low  <= pwdata[BYTE_W-1:0];
        REG_ANGLE_HIGH: cfg.angle_high <= pwdata[BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_SYNC:       prdata = DATA_W'(cfg.sync_byte);
      REG_ANGLE_LOW:  prdata = DATA_W'({cfg.angle_low});
      REG_ANGLE_HIGH: prdata = DATA_W'({cfg.angle_high});
      default:        prdata = '0;
    endcase
  end

  afp_front u_front (
    .clk    (clk),
    .rst    (rst),
    .rx_ch  (rx_ch),
    .cfg    (cfg),
    .q_stat (q_stat),
    .push   (push),
    .desc   (push_desc)
  );

  afp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_desc),
    .pop       (pop),
    .pop_data  (pop_desc),
    .q_stat    (q_stat)
  );

  afp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .sync_byte (cfg.sync_byte),
    .q_stat    (q_stat),
    .q_data    (pop_desc),
    .pop       (pop),
    .tx_ch     (tx_ch)
  );

  `AFP_ASSERT_IMP(a_no_overflow, push, !q_stat.full)
  `AFP_ASSERT_IMP(a_full_stalls, q_stat.full, !rx_ch.ready)
  `AFP_ASSERT_IMP(a_cmd_on_last, tx_ch.valid && tx_ch.cmd_valid, tx_ch.last)
  `AFP_ASSERT_NEXT(a_back_loads, !q_stat.empty && !tx_ch.valid, tx_ch.valid)

endmodule
`default_nettype wire

[sv/afp_front.sv]
// Front end: sync hunt, frame collection and frame classification.
`default_nettype none
module afp_front (
  input  wire logic                  clk,
  input  wire logic                  rst,
  afp_in_if.sink                     rx_ch,
  input  wire afp_pkg::cfg_t         cfg,
  input  wire afp_pkg::queue_status_t q_stat,
  output      logic                  push,
  output      afp_pkg::reply_desc_t  desc
);
  import afp_pkg::*;

  logic [POS_W-1:0]  frame_position;
  logic [POS_W-1:0]  frame_position_next;
  logic [BYTE_W-1:0] frame_store [4];
  logic              accept;
  logic              is_sync;
  logic              store_en;
  logic [1:0]        store_idx;
  logic [BYTE_W-1:0] sum;
  logic              range_ok;

  assign rx_ch.ready = !q_stat.full;
  assign accept      = rx_ch.valid && rx_ch.ready;
  assign is_sync     = rx_ch.rx_byte == cfg.sync_byte;

  always_comb begin
    frame_position_next = frame_position;
    store_en            = 1'b0;
    store_idx           = 2'd0;
    push                = 1'b0;
    if (frame_position == POS_IDLE) begin
      if (is_sync) begin
        store_en            = 1'b1;
        frame_position_next = POS_FIRST;
      end
    end else if (frame_position > POS_FIRST && is_sync) begin
      store_en            = 1'b1;
      frame_position_next = POS_FIRST;
    end else if (frame_position < POS_CSUM) begin
      store_en            = 1'b1;
      store_idx           = frame_position[1:0];
      frame_position_next = frame_position + POS_W'(1);
    end else begin
      frame_position_next = POS_IDLE;
      push                = accept;
    end
  end

  assign sum = frame_store[0] + frame_store[1] + frame_store[2] + frame_store[3];

  always_comb begin
    range_ok = 1'b1;
    for (int i = 1; i < 4; i++) begin
      if ($signed(frame_store[i]) < cfg.angle_low ||
          $signed(frame_store[i]) > cfg.angle_high) begin
        range_ok = 1'b0;
      end
    end
  end

  always_comb begin
    desc.angle_first  = frame_store[1];
    desc.angle_second = frame_store[2];
    desc.angle_third  = frame_store[3];
    if (sum != rx_ch.rx_byte) begin
      desc.kind = REPLY_CSUM;
    end else if (!range_ok) begin
      desc.kind = REPLY_RANGE;
    end else if (rx_ch.queue_full) begin
      desc.kind = REPLY_FULL;
    end else begin
      desc.kind = REPLY_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_position <= POS_IDLE;
    end else if (accept) begin
      frame_position <= frame_position_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && store_en) begin
      frame_store[store_idx] <= rx_ch.rx_byte;
    end
  end

endmodule
`default_nettype wire

[sv/afp_queue.sv]
// Short queue of reply descriptors between front and back end.
`default_nettype none
module afp_queue (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   push,
  input  wire afp_pkg::reply_desc_t   push_data,
  input  wire logic                   pop,
  output      afp_pkg::reply_desc_t   pop_data,
  output      afp_pkg::queue_status_t q_stat
);
  import afp_pkg::*;

  reply_desc_t         slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wptr;
  logic [QPTR_W-1:0]   rptr;
  logic [QCNT_W-1:0]   count;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
  endfunction

  assign q_stat.full  = count == QCNT_W'(QUEUE_DEPTH);
  assign q_stat.empty = count == '0;
  assign pop_data     = slots[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= ptr_inc(wptr);
      end
      if (pop) begin
        rptr <= ptr_inc(rptr);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_data;
    end
  end

endmodule
`default_nettype wire

[sv/afp_back.sv]
// Back end: serializes one reply descriptor into status reply words.
`default_nettype none
module afp_back (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic [7:0]             sync_byte,
  input  wire afp_pkg::queue_status_t q_stat,
  input  wire afp_pkg::reply_desc_t   q_data,
  output      logic                   pop,
  afp_out_if.source                   tx_ch
);
  import afp_pkg::*;

  logic              busy;
  reply_desc_t       cur;
  logic [CNT_W-1:0]  cnt;
  logic [CNT_W-1:0]  last_cnt;
  logic              at_last;
  logic              done;
  logic [BYTE_W-1:0] mode;
  logic [BYTE_W-1:0] code;
  logic              cmd;

  assign last_cnt = (cur.kind == REPLY_FULL) ? LAST_LONG : LAST_SHORT;
  assign at_last  = cnt == last_cnt;
  assign done     = busy && tx_ch.ready && at_last;
  assign pop      = !q_stat.empty && (!busy || done);

  always_comb begin
    case (cur.kind)
      REPLY_OK: begin
        mode = MODE_OK;
        code = CODE_OK;
      end
      REPLY_FULL: begin
        mode = cnt[2] ? MODE_ERR : MODE_OK;
        code = cnt[2] ? CODE_FULL : CODE_OK;
      end
      REPLY_RANGE: begin
        mode = MODE_ERR;
        code = CODE_RANGE;
      end
      default: begin
        mode = MODE_ERR;
        code = CODE_CSUM;
      end
    endcase
  end

  always_comb begin
    case (cnt[1:0])
      2'd0:    tx_ch.tx_byte = sync_byte;
      2'd1:    tx_ch.tx_byte = mode;
      2'd2:    tx_ch.tx_byte = code;
      default: tx_ch.tx_byte = sync_byte + mode + code;
    endcase
  end

  assign cmd                = (cur.kind == REPLY_OK) && at_last;
  assign tx_ch.valid        = busy;
  assign tx_ch.cmd_valid    = cmd;
  assign tx_ch.angle_first  = cmd ? cur.angle_first : '0;
  assign tx_ch.angle_second = cmd ? cur.angle_second : '0;
  assign tx_ch.angle_third  = cmd ? cur.angle_third : '0;
  assign tx_ch.last         = at_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (pop) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (done) begin
      busy <= 1'b0;
    end else if (busy && tx_ch.ready) begin
      cnt <= cnt + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= q_data;
    end
  end

endmodule
`default_nettype wire
